>>> hdl/mtf_pkg.sv
// Shared types and codes for the move-to-front lookup table.
package mtf_pkg;

    // Width of the capacity register
    localparam int CAP_BITS = 6;

    // Request opcodes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        RES_DONE      = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } result_t;

    // Datapath update actions
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_FRONT  = 2'd3
    } action_t;

    // Controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    apply;
        action_t action;
        result_t result;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        cmd_t op;
        logic hit;
        logic full;
    } dp_status_t;

endpackage

>>> hdl/mtf_ctrl.sv
// Controller state machine for the move-to-front lookup table.
module mtf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mtf_pkg::dp_status_t    stat,
    output mtf_pkg::ctrl_cmd_t     ctrl,
    output logic                   busy
);
    import mtf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and the update action for the captured request
    always_comb
    begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.apply   = 1'b0;
        ctrl.action  = ACT_NONE;
        ctrl.result  = RES_DONE;
        busy         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                busy       = 1'b1;
                ctrl.apply = 1'b1;
                state_next = ST_IDLE;
                case (stat.op)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.result = RES_FULL;
                        end
                        else
                        begin
                            ctrl.action = ACT_APPEND;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            ctrl.action = ACT_DELETE;
                        end
                        else
                        begin
                            ctrl.result = RES_NOT_FOUND;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (stat.hit)
                        begin
                            ctrl.action = ACT_FRONT;
                        end
                        else
                        begin
                            ctrl.result = RES_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        ctrl.action = ACT_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mtf_datapath.sv
// Entry cells, parallel key match and result registers for the lookup table.
module mtf_datapath #(
    parameter int ENTRIES    = 32,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mtf_pkg::ctrl_cmd_t              ctrl,
    output mtf_pkg::dp_status_t             stat,
    input  logic [1:0]                      command,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [VALUE_BITS-1:0]           value,
    input  logic                            cfg_we,
    input  logic [mtf_pkg::CAP_BITS-1:0]    cfg_wdata,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [VALUE_BITS-1:0]           found_value,
    output logic [$clog2(ENTRIES)-1:0]      found_position,
    output logic [$clog2(ENTRIES+1)-1:0]    entry_count
);
    import mtf_pkg::*;

    localparam int POS_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int LIM_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    // Entry cells
    logic [KEY_BITS-1:0]   key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] val_reg [ENTRIES];
    logic [KEY_BITS-1:0]   key_up  [ENTRIES];
    logic [VALUE_BITS-1:0] val_up  [ENTRIES];
    logic [KEY_BITS-1:0]   key_dn  [ENTRIES];
    logic [VALUE_BITS-1:0] val_dn  [ENTRIES];

    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [CAP_BITS-1:0]   capacity_reg;

    // Captured request
    cmd_t                  op_reg;
    logic [KEY_BITS-1:0]   ikey_reg;
    logic [VALUE_BITS-1:0] ival_reg;
    logic [ENTRIES-1:0]    incl_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [VALUE_BITS-1:0] fval_reg;
    logic                  hit_reg;
    logic                  full_reg;

    // Match network
    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    incl;
    logic [ENTRIES-1:0]    first;
    logic [POS_BITS-1:0]   pos_comb;
    logic [VALUE_BITS-1:0] fval_comb;
    logic [LIM_BITS-1:0]   limit;
    logic                  full_comb;

    // Result registers
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [VALUE_BITS-1:0] fval_out_reg;
    logic [POS_BITS-1:0]   pos_out_reg;
    logic [CNT_BITS-1:0]   count_out_reg;

    // Neighbour taps for the shifts
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_taps
        if (g < ENTRIES - 1)
        begin : g_up
            assign key_up[g] = key_reg[g+1];
            assign val_up[g] = val_reg[g+1];
        end
        else
        begin : g_up_end
            assign key_up[g] = key_reg[g];
            assign val_up[g] = val_reg[g];
        end
        if (g > 0)
        begin : g_dn
            assign key_dn[g] = key_reg[g-1];
            assign val_dn[g] = val_reg[g-1];
        end
        else
        begin : g_dn_end
            assign key_dn[g] = ikey_reg;
            assign val_dn[g] = fval_reg;
        end
    end

    // Compare the request key in every valid cell and pick the first hit
    always_comb
    begin
        pos_comb  = '0;
        fval_comb = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (CNT_BITS'(i) < count_reg) && (key_reg[i] == key);
        end
        incl[0] = match[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            incl[i] = incl[i-1] | match[i];
        end
        first[0] = match[0];
        for (int i = 1; i < ENTRIES; i++)
        begin
            first[i] = match[i] & ~incl[i-1];
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            pos_comb  = pos_comb | (POS_BITS'(i) & {POS_BITS{first[i]}});
            fval_comb = fval_comb | (val_reg[i] & {VALUE_BITS{first[i]}});
        end
    end

    // Saturate the capacity to the table depth
    always_comb
    begin
        if (LIM_BITS'(capacity_reg) > LIM_BITS'(ENTRIES))
        begin
            limit = LIM_BITS'(ENTRIES);
        end
        else
        begin
            limit = LIM_BITS'(capacity_reg);
        end
        full_comb = LIM_BITS'(count_reg) >= limit;
    end

    // Work out the count after the update
    always_comb
    begin
        case (ctrl.action)
            ACT_APPEND: count_next = count_reg + CNT_BITS'(1);
            ACT_DELETE: count_next = count_reg - CNT_BITS'(1);
            default:    count_next = count_reg;
        endcase
    end

    assign stat.op   = op_reg;
    assign stat.hit  = hit_reg;
    assign stat.full = full_reg;

    // Hold control state: count, capacity and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_BITS'(32);
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (ctrl.apply)
            begin
                count_reg <= count_next;
            end
            done_reg <= ctrl.apply;
        end
    end

    // Capture the request and its match results
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg   <= cmd_t'(command);
            ikey_reg <= key;
            ival_reg <= value;
            incl_reg <= incl;
            pos_reg  <= pos_comb;
            fval_reg <= fval_comb;
            hit_reg  <= |match;
            full_reg <= full_comb;
        end
    end

    // Append, close the gap, or move the hit to the front
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            case (ctrl.action)
                ACT_APPEND:
                begin
                    if (CNT_BITS'(i) == count_reg)
                    begin
                        key_reg[i] <= ikey_reg;
                        val_reg[i] <= ival_reg;
                    end
                end
                ACT_DELETE:
                begin
                    if (incl_reg[i])
                    begin
                        key_reg[i] <= key_up[i];
                        val_reg[i] <= val_up[i];
                    end
                end
                ACT_FRONT:
                begin
                    if (i == 0 || !incl_reg[(i > 0) ? i - 1 : 0])
                    begin
                        key_reg[i] <= key_dn[i];
                        val_reg[i] <= val_dn[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register the result fields
    always_ff @(posedge clk)
    begin
        if (ctrl.apply)
        begin
            status_reg    <= ctrl.result;
            count_out_reg <= count_next;
            fval_out_reg  <= (ctrl.action == ACT_FRONT) ? fval_reg : '0;
            if (ctrl.action == ACT_DELETE || ctrl.action == ACT_FRONT)
            begin
                pos_out_reg <= pos_reg;
            end
            else
            begin
                pos_out_reg <= '0;
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign found_value    = fval_out_reg;
    assign found_position = pos_out_reg;
    assign entry_count    = count_out_reg;

`ifndef SYNTHESIS
    // A result strobe follows every applied update
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.apply |=> done_reg)
        else $error("result strobe missing after update");

    // Never append into a table that was full at capture
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.apply && ctrl.action == ACT_APPEND) |-> !full_reg)
        else $error("append into full table");

    // A delete lowers the count by one
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.apply && ctrl.action == ACT_DELETE) |=>
            count_reg == $past(count_reg) - CNT_BITS'(1))
        else $error("count not lowered by delete");

    // The count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.apply |=> count_reg <= CNT_BITS'(ENTRIES))
        else $error("count beyond table depth");
`endif

endmodule

>>> hdl/move_to_front_lookup_table_unit.sv
// Top level of the move-to-front lookup table: controller plus datapath.
// A request taken while idle is matched over all cells and captured, then the shift is
// applied and the result strobe registered; no new request is taken while shifting.
// busy is high during the shift cycle; results are strobed for one cycle and cannot stall.
// Reset (rst_n, asynchronous, active low) empties the table and sets capacity to 32.
// Entry contents are not cleared by reset; only positions below the count are ever read.
module move_to_front_lookup_table_unit #(
    parameter int ENTRIES    = 32,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [VALUE_BITS-1:0]           value,
    input  logic                            cfg_we,
    input  logic [mtf_pkg::CAP_BITS-1:0]    cfg_wdata,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [VALUE_BITS-1:0]           found_value,
    output logic [$clog2(ENTRIES)-1:0]      found_position,
    output logic [$clog2(ENTRIES+1)-1:0]    entry_count
);
    import mtf_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    // Sequence each request
    mtf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Hold the entries and build results
    mtf_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .command        (command),
        .key            (key),
        .value          (value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .status         (status),
        .found_value    (found_value),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

endmodule
